>>> hw/rtl/tremolo_modulator_assert.svh
// assertion macros shared by the tremolo modulator checker
// no dependencies; included inside module bodies
`ifndef TREMOLO_MODULATOR_ASSERT_SVH
`define TREMOLO_MODULATOR_ASSERT_SVH

// implication checked every edge outside reset
`define TREMO_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define TREMO_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds during reset
`define TREMO_ASSERT_RST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tremo_pkg.sv
// shared widths, register indexes and constants of the tremolo modulator
// no dependencies
package tremo_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int RESULT_W   = 17;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 24;

  localparam int STEP_W     = 10;
  localparam int DEPTH_W    = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam int FRAC_W     = 8;
  localparam int ENTRY_W    = 16;
  localparam int INTERP_W   = 17;

  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEPTH      = 1'd1;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 10'd55;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd32767;
  localparam logic [15:0]        AMP_BIAS    = 16'h8000;

  // quarter wave in q62 and taylor denominators (2k)(2k+1) for the table build
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] TAYLOR_DEN [12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

endpackage

>>> hw/rtl/tremo_sine_rom.sv
// full-scale sine rom with a registered read port, contents built at elaboration
// depends on tremo_pkg
module tremo_sine_rom #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic [$clog2(TABLE_DEPTH)-1:0]        rd_addr,
  output logic signed [tremo_pkg::ENTRY_W-1:0]  rd_data
);
  import tremo_pkg::*;

  typedef logic signed [ENTRY_W-1:0] rom_t [TABLE_DEPTH];

  localparam logic [63:0] BASE_STEP = HALF_PI_Q62 / TABLE_DEPTH;
  localparam logic [63:0] BASE_REM  = HALF_PI_Q62 % TABLE_DEPTH;

  // (a * b) >> 62, kept to 64 bits
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // taylor series of sin on the first quadrant, q62
  function automatic logic [63:0] sin_q62(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k <= 12; k++) begin
      term = mul_q62(term, x2) / TAYLOR_DEN[k-1];
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] quarter;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] v;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      quarter = 64'(4 * i);
      q = quarter / TABLE_DEPTH;
      r = quarter % TABLE_DEPTH;
      x = BASE_STEP * r + (BASE_REM * r) / TABLE_DEPTH;
      if (q[0]) x = HALF_PI_Q62 - x;
      s = sin_q62(x);
      v = (64'd32767 * (s >> 20) + (64'd1 << 41)) >> 42;
      if (v > 64'd32767) v = 64'd32767;
      rom[i] = (q >= 64'd2) ? -$signed(v[ENTRY_W-1:0]) : $signed(v[ENTRY_W-1:0]);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic signed [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    rd_data_r <= SINE_ROM[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/tremolo_modulator.sv
// tremolo modulator: sine nco with interpolation scaling a sample stream
// Usage: audio samples enter on the in_ stream (tdata holds sample_in) and
// leave as modulated samples on the out_ stream (tdata holds sample_out,
// sign bits not extended, upper bits zero). Every input transfer yields
// exactly one output transfer, in order.
// Each sample advances an 18-bit phase accumulator (at 1024 entries) by
// phase_step; the phase picks two neighboring entries of the sine rom,
// which has one registered read port, so the two entries are read in turn.
// Steps from input transfer to out_tvalid, in order: phase and first
// read, second read, depth scaling, output multiply.
// A new sample waits until the last one is done: the next sample is taken
// in the cycle its predecessor is written to the output register.
// Stall: when the receiver holds out_tready low, the finished result waits
// in the output register and one more sample runs up to the final stage;
// in_tready stays low until the output register frees.
// Reset (rst_n low, synchronous): phase cleared, phase_step 55, depth 32767,
// output emptied. The rom is constant, so no clearing pass is needed.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr
// (0 phase_step, 1 depth); write only while the block is idle.
// depends on tremo_pkg and tremo_sine_rom
module tremolo_modulator #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample stream in, tdata: [15:0] sample_in
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tremo_pkg::IN_TDATA_W-1:0]    in_tdata,
  // sample stream out, tdata: [16:0] sample_out, [23:17] zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tremo_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // register writes
  input  logic                                cfg_we,
  input  logic [tremo_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [tremo_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tremo_pkg::*;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int PHASE_W = ADDR_W + FRAC_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  logic [PHASE_W-1:0]         phase_r, phase_nxt;
  logic [STEP_W-1:0]          step_r;
  logic [DEPTH_W-1:0]         depth_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [INTERP_W-1:0] part1_r;
  logic signed [INTERP_W-1:0] interp_r;
  logic [15:0]                amp_r;
  logic                       out_valid_r;
  logic [RESULT_W-1:0]        out_data_r;

  logic                       in_fire;
  logic                       out_free;
  logic                       out_load;
  logic [ADDR_W-1:0]          rom_addr;
  logic signed [ENTRY_W-1:0]  rom_data;
  logic [FRAC_W-1:0]          frac;
  logic signed [24:0]         prod1;
  logic signed [24:0]         prod2;
  logic signed [33:0]         prod_m;
  logic signed [32:0]         prod_y;

  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = (state_r == S_OUT) && out_free;
  assign in_tready = (state_r == S_IDLE) || out_load;
  assign in_fire   = in_tvalid && in_tready;

  // phase wraps at the table span by width
  assign phase_nxt = phase_r + {{(PHASE_W-STEP_W){1'b0}}, step_r};
  assign frac      = phase_r[FRAC_W-1:0];

  // first read at the transfer, neighbor entry in the next cycle
  assign rom_addr = in_fire ? phase_nxt[PHASE_W-1:FRAC_W]
                            : phase_r[PHASE_W-1:FRAC_W] + 1'b1;

  tremo_sine_rom #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // interpolation weights are frac and 255-frac
  assign prod1  = rom_data * $signed({1'b0, ~frac});
  assign prod2  = rom_data * $signed({1'b0, frac});
  assign prod_m = interp_r * $signed({1'b0, depth_r});
  assign prod_y = sample_r * $signed({1'b0, amp_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_RD1;
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_MOD;
      S_MOD:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) state_nxt = in_fire ? S_RD1 : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      step_r      <= STEP_RESET;
      depth_r     <= DEPTH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) phase_r <= phase_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_PHASE_STEP: step_r  <= cfg_wdata[STEP_W-1:0];
          REG_DEPTH:      depth_r <= cfg_wdata[DEPTH_W-1:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) sample_r <= $signed(in_tdata[SAMPLE_W-1:0]);
    if (state_r == S_RD1) part1_r <= prod1[24:8];
    if (state_r == S_RD2) interp_r <= prod2[24:8] + part1_r;
    if (state_r == S_MOD) amp_r <= prod_m[31:16] + AMP_BIAS;
    if (out_load) out_data_r <= prod_y[31:15];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, out_data_r};

endmodule

>>> hw/rtl/tremo_checker.sv
// port-level checker for the tremolo modulator, bound to the top level
// depends on tremo_pkg and tremolo_modulator_assert.svh
module tremo_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [tremo_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  `include "tremolo_modulator_assert.svh"

  logic in_xfer;

  assign in_xfer = in_tvalid && in_tready;

  // a stalled result holds
  `TREMO_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  // a new result must follow a taken sample
  `TREMO_ASSERT_IMP(a_out_latency, clk, rst_n, $rose(out_tvalid), $past(in_xfer, 5), "result without matching sample")
  // no new sample is taken while the last one is still in the read and scaling steps
  `TREMO_ASSERT_NXT(a_in_spacing, clk, rst_n, in_xfer, !in_tready ##1 !in_tready ##1 !in_tready, "sample taken too early")
  // reset empties the output
  `TREMO_ASSERT_RST(a_reset_empty, clk, !rst_n, !out_tvalid, "output valid after reset")

endmodule

bind tremolo_modulator tremo_checker u_tremo_checker (.*);

>>> sim/tremolo_checker.sv
// tremolo modulator checker: watches the sample streams and the register port,
// predicts every modulated sample and compares it with the block's output
// depends on tremo_pkg
module tremolo_checker #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [tremo_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [tremo_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              cfg_we,
  input  logic [tremo_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tremo_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                                n_fail,
  output int                                n_pending,
  output int                                n_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import tremo_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int PHASE_W = IDX_W + FRAC_W;

  logic signed [ENTRY_W-1:0] sine_lut [TABLE_DEPTH];
  logic [PHASE_W-1:0]        phase_acc;
  logic [STEP_W-1:0]         step_reg;
  logic [DEPTH_W-1:0]        depth_reg;
  logic [RESULT_W-1:0]       want_samples [$];

  // (a * b) >> 62 on unsigned q62 values, kept to 64 bits
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // taylor sine over the first quadrant, q62 in and out
  function automatic logic [63:0] q62_sine(input logic [63:0] x);
    logic [63:0] x2, term, sum;
    int k;
    x2 = q62_mul(x, x);
    term = x;
    sum = x;
    for (k = 1; k <= 12; k++) begin
      term = q62_mul(term, x2) / (64'(2 * k) * 64'(2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  task automatic fill_sine_lut();
    logic [63:0] base, rem, quarter, quad, r, x, v, depth64;
    int i;
    depth64 = 64'(TABLE_DEPTH);
    base = HALF_PI_Q62 / depth64;
    rem = HALF_PI_Q62 % depth64;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      quarter = 64'(4 * i);
      quad = quarter / depth64;
      r = quarter % depth64;
      x = base * r + (rem * r) / depth64;
      if (quad[0]) x = HALF_PI_Q62 - x;
      v = (64'd32767 * (q62_sine(x) >> 20) + (64'd1 << 41)) >> 42;
      if (v > 64'd32767) v = 64'd32767;
      sine_lut[i] = (quad >= 2) ? -$signed(v[15:0]) : $signed(v[15:0]);
    end
  endtask

  // interpolated sine, scaled by depth and biased, times the sample
  function automatic logic [RESULT_W-1:0] tremolo_sample(
    input logic signed [SAMPLE_W-1:0] smp,
    input logic [PHASE_W-1:0]         ph,
    input logic [DEPTH_W-1:0]         dep
  );
    logic [IDX_W-1:0] idx, nxt;
    logic [7:0]       frac;
    longint           interp, scaled, amp, y;
    idx = ph[PHASE_W-1:FRAC_W];
    nxt = idx + 1'b1;
    frac = ph[FRAC_W-1:0];
    // weights frac and 255-frac: they sum to 255 by design
    interp = ((longint'(sine_lut[nxt]) * longint'(frac)) >>> 8)
           + ((longint'(sine_lut[idx]) * longint'(8'd255 - frac)) >>> 8);
    scaled = (interp * longint'(dep)) >>> 16;
    amp = (scaled + longint'(AMP_BIAS)) & 64'hffff;
    y = (longint'(smp) * amp) >>> 15;
    return y[RESULT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("tremolo_checker: %0t: %s", $time, what);
    n_fail++;
  endtask

  initial begin
    n_fail = 0;
    n_pending = 0;
    n_checked = 0;
    fill_sine_lut();
  end

  always @(posedge clk) begin
    logic [RESULT_W-1:0] want;
    if (!rst_n) begin
      want_samples.delete();
      phase_acc = '0;
      step_reg = STEP_RESET;
      depth_reg = DEPTH_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PHASE_STEP: step_reg = cfg_wdata[STEP_W-1:0];
          REG_DEPTH: depth_reg = cfg_wdata[DEPTH_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        phase_acc = phase_acc + PHASE_W'(step_reg);
        want_samples.push_back(tremolo_sample(in_tdata[SAMPLE_W-1:0], phase_acc, depth_reg));
      end
      if (out_tvalid && out_tready) begin
        if (want_samples.size() == 0) begin
          report_mismatch($sformatf("output transfer %h with no sample outstanding",
                                    out_tdata));
        end else begin
          want = want_samples.pop_front();
          n_checked++;
          if (out_tdata[RESULT_W-1:0] !== want)
            report_mismatch($sformatf("sample_out %h, predicted %h",
                                      out_tdata[RESULT_W-1:0], want));
        end
      end
    end
    n_pending = want_samples.size();
  end

endmodule

>>> sim/tb_top.sv
// top of the tremolo modulator testbench: clock, reset, stimulus and verdict
// depends on tremo_pkg, tremolo_modulator and tremolo_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tremo_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int PHASE_W     = $clog2(TABLE_DEPTH) + FRAC_W;
  localparam int MAX_STEP    = (1 << STEP_W) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CHUNK       = 42;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int n_fail, n_pending, n_checked;
  int n_cycles = 0;
  int n_sent = 0;
  int n_writes = 0;
  int n_wraps = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic [STEP_W-1:0]  step_now = STEP_RESET;
  logic [PHASE_W-1:0] phase_pos = '0;

  tremolo_modulator #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  tremolo_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .n_fail(n_fail), .n_pending(n_pending), .n_checked(n_checked)
  );

  always #4 clk = ~clk;

  always @(negedge clk) out_tready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles", n_cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    logic [PHASE_W-1:0] next_pos;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata = 16'($urandom);
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = smp;
    do @(posedge clk); while (!in_tready);
    next_pos = phase_pos + PHASE_W'(step_now);
    if (next_pos < phase_pos) n_wraps++;
    phase_pos = next_pos;
    n_sent++;
  endtask

  // sender holds off until every outstanding sample has come back
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = data;
    if (addr == REG_PHASE_STEP) step_now = data[STEP_W-1:0];
    n_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] step, input logic [CFG_DATA_W-1:0] dep);
    drain();
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_DEPTH, dep);
  endtask

  task automatic rand_configure();
    logic [CFG_DATA_W-1:0] step, dep;
    case ($urandom_range(9))
      0, 1, 2: step = CFG_DATA_W'(MAX_STEP);
      3: step = 16'd1;
      4: step = 16'd0;
      default: step = CFG_DATA_W'($urandom_range(MAX_STEP, 1));
    endcase
    // junk above the step field must be dropped
    step[CFG_DATA_W-1:STEP_W] = ($urandom_range(3) == 0) ? '1 : '0;
    case ($urandom_range(7))
      0, 1: dep = 16'hffff;
      2: dep = 16'h0000;
      default: dep = 16'($urandom);
    endcase
    configure(step, dep);
  endtask

  // steer the phase onto the last table entry with a nonzero fraction, then wrap
  task automatic reach_last_entry();
    logic [PHASE_W-1:0] target, gap;
    target = PHASE_W'((TABLE_DEPTH - 1) * 256 + $urandom_range(255, 1));
    configure({6'h3f, 10'(MAX_STEP)}, 16'hffff);
    gap = target - phase_pos;
    while (gap > PHASE_W'(MAX_STEP)) begin
      send_sample(rand_sample());
      gap = gap - PHASE_W'(MAX_STEP);
    end
    drain();
    write_reg(REG_PHASE_STEP, CFG_DATA_W'(gap));
    send_sample(rand_sample());
    configure(CFG_DATA_W'(MAX_STEP), 16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h8000);
  endtask

  initial begin
    int p, c, i;
    logic [SAMPLE_W-1:0] extremes [8];
    extremes = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5555,
                 16'haaaa, 16'h8001};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, full-scale settings with junk high bits,
    // frozen phase with zero depth, slowest step
    for (i = 0; i < 8; i++) send_sample(extremes[i]);
    configure(16'hffff, 16'hffff);
    for (i = 0; i < 8; i++) send_sample(extremes[i]);
    configure(16'h0000, 16'h0000);
    for (i = 0; i < 4; i++) send_sample(extremes[i]);
    configure(16'h0001, 16'h0001);
    for (i = 0; i < 4; i++) send_sample(extremes[i + 4]);

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      if (p == 0 || p == 2) reach_last_entry();
      for (c = 0; c < 3; c++) begin
        rand_configure();
        repeat (CHUNK) send_sample(rand_sample());
      end
    end

    drain();
    $display("tb_top: %0d samples sent, %0d results checked, %0d register writes",
             n_sent, n_checked, n_writes);
    $display("tb_top: four handshake profiles, phase wrapped %0d times", n_wraps);
    if (n_fail == 0 && n_pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
